@@ rtl/core/two_rate_three_color_meter_core_defines.svh @@
// Assertion macros used by the meter checker.
// Standalone header; no dependencies.
`ifndef TWO_RATE_THREE_COLOR_METER_CORE_DEFINES_SVH
`define TWO_RATE_THREE_COLOR_METER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TRTCM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trtcm check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TRTCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trtcm check failed");

`endif

@@ rtl/core/trtcm_pkg.sv @@
// Shared types and constants for the two-rate three-color meter.
// No dependencies; used by the core and its checker.
`timescale 1ns / 1ps

package trtcm_pkg;

    localparam int TIME_BITS_DEF      = 48;
    localparam int RATE_FRAC_BITS_DEF = 16;

    localparam int RATE_W     = 32;   // rate and bucket registers
    localparam int BYTES_W    = 16;
    localparam int NEED_W     = BYTES_W + 3;  // bytes times eight
    localparam int COLOR_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MUL_W      = 32;   // operand width of one partial product
    localparam int ELAPSED_W  = 2 * MUL_W;

    localparam logic [COLOR_W-1:0] COLOR_GREEN  = 2'd0;
    localparam logic [COLOR_W-1:0] COLOR_YELLOW = 2'd1;
    localparam logic [COLOR_W-1:0] COLOR_RED    = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PEAK_RATE   = 3'd0,
        CFG_PEAK_BURST  = 3'd1,
        CFG_COMMIT_RATE = 3'd2,
        CFG_COMMIT_BURST = 3'd3,
        CFG_COLOR_AWARE = 3'd4
    } cfg_index_t;

endpackage

@@ rtl/core/two_rate_three_color_meter_core.sv @@
// Two-rate three-color meter core (RFC 2698 style trTCM).
// Depends on trtcm_pkg.
`timescale 1ns / 1ps

// Usage:
// Input channel (in_valid / in_stall) carries one packet descriptor per
// transaction: arrival_time, packet_bytes and in_color. Output channel
// (out_valid / out_stall) returns one out_color per packet, in order.
// Configuration is a write-only port (cfg_wr_en, cfg_index, cfg_data); write
// only while no packet is in flight. A burst-size write also refills its bucket.
// Throughput: one packet per cycle while the receiver does not stall.
// Registered stages: elapsed-time subtract, 32x32 partial products for both
// buckets, product recombine with truncation and overflow flag, then the
// combinational token loop (refill, saturate, compare, debit) that feeds the
// output register. That loop is what fixes the one-packet-per-cycle rate.
// Reset zeroes the valid flags, configuration, both buckets and last arrival
// time, not payload registers. When the receiver stalls, the output holds;
// bubbles still fill, and in_stall rises once every pipeline stage is occupied.
module two_rate_three_color_meter_core #(
    parameter int TIME_BITS      = trtcm_pkg::TIME_BITS_DEF,
    parameter int RATE_FRAC_BITS = trtcm_pkg::RATE_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [TIME_BITS-1:0]               arrival_time,
    input  logic [trtcm_pkg::BYTES_W-1:0]      packet_bytes,
    input  logic [trtcm_pkg::COLOR_W-1:0]      in_color,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [trtcm_pkg::COLOR_W-1:0]      out_color,
    input  logic                               cfg_wr_en,
    input  logic [trtcm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [trtcm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int RW  = trtcm_pkg::RATE_W;
    localparam int MW  = trtcm_pkg::MUL_W;
    localparam int PW  = 2 * MW;          // partial product width
    localparam int FW  = 3 * MW;          // full product width
    localparam int NW  = trtcm_pkg::NEED_W;
    localparam int CW  = trtcm_pkg::COLOR_W;
    localparam int ELAPSED_W_L = trtcm_pkg::ELAPSED_W;

    // configuration
    logic [RW-1:0] peak_rate_reg, peak_burst_reg, commit_rate_reg, commit_burst_reg;
    logic          color_aware_reg;

    // bucket state
    logic [RW-1:0]        peak_tok_reg, commit_tok_reg;
    logic [RW-1:0]        peak_tok_next, commit_tok_next;
    logic [TIME_BITS-1:0] last_time_reg;

    // stage 1: elapsed time
    logic                 s1_valid_reg;
    logic [TIME_BITS-1:0] s1_elapsed_reg, s1_elapsed_next;
    logic [NW-1:0]        s1_need_reg;
    logic [CW-1:0]        s1_color_reg;

    // stage 2: partial products
    logic          s2_valid_reg;
    logic [PW-1:0] s2_pk_lo_reg, s2_pk_hi_reg, s2_cm_lo_reg, s2_cm_hi_reg;
    logic [PW-1:0] s2_pk_lo_next, s2_pk_hi_next, s2_cm_lo_next, s2_cm_hi_next;
    logic [NW-1:0] s2_need_reg;
    logic [CW-1:0] s2_color_reg;

    // stage 3: truncated refill amounts
    logic          s3_valid_reg;
    logic [RW-1:0] s3_pk_add_reg, s3_cm_add_reg, s3_pk_add_next, s3_cm_add_next;
    logic          s3_pk_ovf_reg, s3_cm_ovf_reg, s3_pk_ovf_next, s3_cm_ovf_next;
    logic [NW-1:0] s3_need_reg;
    logic [CW-1:0] s3_color_reg;

    // output
    logic          out_valid_reg;
    logic [CW-1:0] out_color_reg, out_color_next;

    logic ready_out, ready3, ready2, ready1;
    logic fire;

    logic [ELAPSED_W_L-1:0] elapsed_wide;

    logic [FW-1:0] pk_full, cm_full;
    logic [RW:0]   pk_sum, cm_sum;
    logic [RW-1:0] pk_fill, cm_fill;
    logic [RW-1:0] need_ext;
    logic [CW-1:0] pre;

    // ---------------------------------------------------------------- flow
    assign ready_out = !out_valid_reg || !out_stall;
    assign ready3    = !s3_valid_reg || ready_out;
    assign ready2    = !s2_valid_reg || ready3;
    assign ready1    = !s1_valid_reg || ready2;
    assign in_stall  = !ready1;
    assign fire      = s3_valid_reg && ready_out;

    assign out_valid = out_valid_reg;
    assign out_color = out_color_reg;

    // ---------------------------------------------------------------- datapath
    always_comb
    begin
        s1_elapsed_next = arrival_time - last_time_reg;

        elapsed_wide  = ELAPSED_W_L'(s1_elapsed_reg);
        s2_pk_lo_next = PW'(elapsed_wide[MW-1:0])  * PW'(peak_rate_reg);
        s2_pk_hi_next = PW'(elapsed_wide[PW-1:MW]) * PW'(peak_rate_reg);
        s2_cm_lo_next = PW'(elapsed_wide[MW-1:0])  * PW'(commit_rate_reg);
        s2_cm_hi_next = PW'(elapsed_wide[PW-1:MW]) * PW'(commit_rate_reg);

        pk_full = FW'(s2_pk_lo_reg) + {s2_pk_hi_reg, {MW{1'b0}}};
        cm_full = FW'(s2_cm_lo_reg) + {s2_cm_hi_reg, {MW{1'b0}}};
        // drop the fraction; anything above 32 whole bits saturates the bucket
        s3_pk_add_next = pk_full[RW+RATE_FRAC_BITS-1:RATE_FRAC_BITS];
        s3_cm_add_next = cm_full[RW+RATE_FRAC_BITS-1:RATE_FRAC_BITS];
        s3_pk_ovf_next = |pk_full[FW-1:RW+RATE_FRAC_BITS];
        s3_cm_ovf_next = |cm_full[FW-1:RW+RATE_FRAC_BITS];
    end

    // token loop: refill, saturate, mark, debit
    always_comb
    begin
        pk_sum  = {1'b0, peak_tok_reg} + {1'b0, s3_pk_add_reg};
        cm_sum  = {1'b0, commit_tok_reg} + {1'b0, s3_cm_add_reg};
        pk_fill = (s3_pk_ovf_reg || (pk_sum > {1'b0, peak_burst_reg}))
                  ? peak_burst_reg : pk_sum[RW-1:0];
        cm_fill = (s3_cm_ovf_reg || (cm_sum > {1'b0, commit_burst_reg}))
                  ? commit_burst_reg : cm_sum[RW-1:0];
        need_ext = RW'(s3_need_reg);
        pre      = color_aware_reg ? s3_color_reg : trtcm_pkg::COLOR_GREEN;

        peak_tok_next   = pk_fill;
        commit_tok_next = cm_fill;
        if ((pre == trtcm_pkg::COLOR_RED) || (need_ext > pk_fill))
        begin
            out_color_next = trtcm_pkg::COLOR_RED;
        end
        else if ((pre == trtcm_pkg::COLOR_YELLOW) || (need_ext > cm_fill))
        begin
            out_color_next = trtcm_pkg::COLOR_YELLOW;
            peak_tok_next  = pk_fill - need_ext;
        end
        else
        begin
            out_color_next  = trtcm_pkg::COLOR_GREEN;
            peak_tok_next   = pk_fill - need_ext;
            commit_tok_next = cm_fill - need_ext;
        end
    end

    // ---------------------------------------------------------------- control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            last_time_reg <= '0;
        end
        else
        begin
            if (ready1)
                s1_valid_reg <= in_valid;
            if (ready2)
                s2_valid_reg <= s1_valid_reg;
            if (ready3)
                s3_valid_reg <= s2_valid_reg;
            if (ready_out)
                out_valid_reg <= s3_valid_reg;
            if (in_valid && ready1)
                last_time_reg <= arrival_time;
        end
    end

    // configuration and bucket state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_rate_reg    <= '0;
            peak_burst_reg   <= '0;
            commit_rate_reg  <= '0;
            commit_burst_reg <= '0;
            color_aware_reg  <= 1'b0;
            peak_tok_reg     <= '0;
            commit_tok_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                trtcm_pkg::CFG_PEAK_RATE:
                    peak_rate_reg <= cfg_data;
                trtcm_pkg::CFG_PEAK_BURST:
                begin
                    peak_burst_reg <= cfg_data;
                    peak_tok_reg   <= cfg_data;
                end
                trtcm_pkg::CFG_COMMIT_RATE:
                    commit_rate_reg <= cfg_data;
                trtcm_pkg::CFG_COMMIT_BURST:
                begin
                    commit_burst_reg <= cfg_data;
                    commit_tok_reg   <= cfg_data;
                end
                trtcm_pkg::CFG_COLOR_AWARE:
                    color_aware_reg <= cfg_data[0];
                default:
                    ;  // drop writes to unused indexes
            endcase
        end
        else if (fire)
        begin
            peak_tok_reg   <= peak_tok_next;
            commit_tok_reg <= commit_tok_next;
        end
    end

    // ---------------------------------------------------------------- payload
    always_ff @(posedge clk)
    begin
        if (in_valid && ready1)
        begin
            s1_elapsed_reg <= s1_elapsed_next;
            s1_need_reg    <= {packet_bytes, 3'b000};
            s1_color_reg   <= in_color;
        end
        if (s1_valid_reg && ready2)
        begin
            s2_pk_lo_reg <= s2_pk_lo_next;
            s2_pk_hi_reg <= s2_pk_hi_next;
            s2_cm_lo_reg <= s2_cm_lo_next;
            s2_cm_hi_reg <= s2_cm_hi_next;
            s2_need_reg  <= s1_need_reg;
            s2_color_reg <= s1_color_reg;
        end
        if (s2_valid_reg && ready3)
        begin
            s3_pk_add_reg <= s3_pk_add_next;
            s3_cm_add_reg <= s3_cm_add_next;
            s3_pk_ovf_reg <= s3_pk_ovf_next;
            s3_cm_ovf_reg <= s3_cm_ovf_next;
            s3_need_reg   <= s2_need_reg;
            s3_color_reg  <= s2_color_reg;
        end
        if (fire)
            out_color_reg <= out_color_next;
    end

endmodule

@@ rtl/core/trtcm_checker.sv @@
// Port-level checker for the two-rate three-color meter core, bound to it.
// Depends on trtcm_pkg and two_rate_three_color_meter_core_defines.svh.
`timescale 1ns / 1ps
`include "two_rate_three_color_meter_core_defines.svh"

module trtcm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [trtcm_pkg::COLOR_W-1:0] out_color
);

    // a result is always one of the three colors
    `TRTCM_ASSERT_IMPLY(a_color_legal, clk, rst_n, out_valid, (out_color == trtcm_pkg::COLOR_GREEN) || (out_color == trtcm_pkg::COLOR_YELLOW) || (out_color == trtcm_pkg::COLOR_RED))

    // a stalled result holds
    `TRTCM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_color))

    // an empty output register means the pipeline can take a transaction
    `TRTCM_ASSERT_IMPLY(a_no_false_stall, clk, rst_n, !out_valid, !in_stall)

    // with the receiver kept open, an accepted transaction raises out_valid
    `TRTCM_ASSERT_NEXT(a_latency, clk, rst_n, (in_valid && !in_stall && !out_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall, out_valid)

endmodule

bind two_rate_three_color_meter_core trtcm_checker u_trtcm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_color (out_color)
);
